FILE: sv/time_band_match_search_macros.svh
// Assertion macros of the time band match search port checker.
`ifndef TIME_BAND_MATCH_SEARCH_MACROS_SVH
`define TIME_BAND_MATCH_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TBMS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TBMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tbms_pkg.sv
// Shared types and constants of the time band match search block.
package tbms_pkg;

  localparam int TableDepthDefault = 1024;
  localparam int BracketLimit      = 10;

  localparam int CountW      = 11;
  localparam int IndexW      = 10;
  localparam int TimeW       = 32;
  localparam int CodeW       = 16;
  localparam int InDataW     = 64;
  localparam int OutDataW    = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } tbms_op_e;

  typedef struct packed {
    logic signed [TimeW-1:0] time_val;
    logic signed [CodeW-1:0] code_val;
  } tbms_entry_t;

endpackage

FILE: sv/tbms_table.sv
// Entry table: one write port, one read port with registered read data.
module tbms_table
  import tbms_pkg::*;
#(
  parameter int Depth = TableDepthDefault,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  tbms_entry_t       wr_entry_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output tbms_entry_t       rd_entry_o
);

  tbms_entry_t mem_q [Depth];
  tbms_entry_t rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_entry_q <= mem_q[rd_addr_i];
  end

  assign rd_entry_o = rd_entry_q;

endmodule

FILE: sv/time_band_match_search.sv
// Top level of the time band match search: bracketed bisection and scan sequencer.
//
//  channel  | dir | fields (low bit up)                                  | handshake
//  s_axis   | in  | tuser: operation; tdata: entry_index, time, code     | tvalid/tready
//  m_axis   | out | tuser: found; tdata: match_index                     | tvalid/tready
//  cfg      | in  | cfg_wr_data_i: entry_count                           | cfg_wr_en_i
//
//  A write beat leaves the input ready. A query runs L lower and U upper bisection
//  steps and then scans S entries, each step and each scanned entry passing a check
//  state and a compare state through the single table read port and its registered
//  read data; an unsorted table can widen the scan to the whole count.
//  The table has no reset; entries read as undefined until written.
//  A finished result waits in the output register; the next query holds in its
//  last cycle while that result is not taken.
module time_band_match_search
  import tbms_pkg::*;
#(
  parameter int TableDepth = TableDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [CountW-1:0]   cfg_wr_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // entry_index, key_time, key_code, zero pad
  input  logic [0:0]          s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // match_index, zero pad
  output logic [0:0]          m_axis_tuser    // found
);

  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int CmpW  = (CntW > CountW) ? CntW : CountW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO_CHK,
    ST_LO_CMP,
    ST_HI_CHK,
    ST_HI_CMP,
    ST_SCAN_CHK,
    ST_SCAN_CMP,
    ST_FINISH
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   entry_count_q, entry_count_d;
  logic [CntW-1:0]     lo_q, lo_d, hi_q, hi_d, first_q, first_d, cnt_q, cnt_d;
  logic [TimeW-1:0]    key_time_q, key_time_d;
  logic [CodeW-1:0]    key_code_q, key_code_d;
  logic                res_found_q, res_found_d;
  logic                m_valid_q, m_valid_d;
  logic                m_found_q, m_found_d;
  logic [IndexW-1:0]   m_idx_q, m_idx_d;

  tbms_op_e            in_op;
  logic [IndexW-1:0]   in_index;
  logic [TimeW-1:0]    in_time;
  logic [CodeW-1:0]    in_code;
  logic                s_beat;
  logic                tbl_wr_en;
  logic [AddrW-1:0]    tbl_rd_addr;
  tbms_entry_t         tbl_wr_entry, tbl_rd_entry;
  logic [CntW:0]       mid_sum;
  logic [CntW-1:0]     mid;
  logic                span_open;
  logic signed [TimeW-1:0] cmp_a, cmp_b;
  logic                cmp_less;
  logic                hit;
  logic [CntW-1:0]     cnt_clamp;

  assign in_op    = tbms_op_e'(s_axis_tuser[0]);
  assign in_index = s_axis_tdata[IndexW-1:0];
  assign in_time  = s_axis_tdata[IndexW+TimeW-1:IndexW];
  assign in_code  = s_axis_tdata[IndexW+TimeW+CodeW-1:IndexW+TimeW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  assign tbl_wr_en = s_beat && (in_op == OP_WRITE) &&
                     (32'(in_index) < 32'(TableDepth));
  assign tbl_wr_entry.time_val = in_time;
  assign tbl_wr_entry.code_val = in_code;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[CntW:1];
  assign span_open = (hi_q > lo_q) && ((hi_q - lo_q) > CntW'(BracketLimit));

  assign tbl_rd_addr = (state_q == ST_LO_CHK || state_q == ST_HI_CHK) ?
                       AddrW'(mid) : AddrW'(lo_q);

  // shared signed compare: lower search asks entry < key, upper asks key < entry
  assign cmp_a    = (state_q == ST_LO_CMP) ? tbl_rd_entry.time_val : key_time_q;
  assign cmp_b    = (state_q == ST_LO_CMP) ? key_time_q : tbl_rd_entry.time_val;
  assign cmp_less = cmp_a < cmp_b;
  assign hit      = (tbl_rd_entry.time_val == key_time_q) &&
                    (tbl_rd_entry.code_val == key_code_q);

  assign cnt_clamp = (CmpW'(entry_count_q) > CmpW'(TableDepth)) ?
                     CntW'(TableDepth) : CntW'(entry_count_q);

  tbms_table #(
    .Depth (TableDepth)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (tbl_wr_en),
    .wr_addr_i  (AddrW'(32'(in_index))),
    .wr_entry_i (tbl_wr_entry),
    .rd_addr_i  (tbl_rd_addr),
    .rd_entry_o (tbl_rd_entry)
  );

  always_comb begin
    state_d       = state_q;
    entry_count_d = entry_count_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    first_d       = first_q;
    cnt_d         = cnt_q;
    key_time_d    = key_time_q;
    key_code_d    = key_code_q;
    res_found_d   = res_found_q;
    m_valid_d     = m_valid_q;
    m_found_d     = m_found_q;
    m_idx_d       = m_idx_q;

    if (cfg_wr_en_i) begin
      entry_count_d = cfg_wr_data_i;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_beat && in_op == OP_QUERY) begin
          key_time_d = in_time;
          key_code_d = in_code;
          cnt_d      = cnt_clamp;
          lo_d       = '0;
          hi_d       = cnt_clamp;
          state_d    = ST_LO_CHK;
        end
      end
      ST_LO_CHK: begin
        if (span_open) begin
          state_d = ST_LO_CMP;
        end else begin
          first_d = lo_q;
          lo_d    = '0;
          hi_d    = cnt_q;
          state_d = ST_HI_CHK;
        end
      end
      ST_LO_CMP: begin
        if (cmp_less) begin
          lo_d = mid;
        end else begin
          hi_d = mid + CntW'(1);
        end
        state_d = ST_LO_CHK;
      end
      ST_HI_CHK: begin
        if (span_open) begin
          state_d = ST_HI_CMP;
        end else begin
          lo_d    = first_q;
          state_d = ST_SCAN_CHK;
        end
      end
      ST_HI_CMP: begin
        if (cmp_less) begin
          hi_d = mid;
        end else begin
          lo_d = mid - CntW'(1);
        end
        state_d = ST_HI_CHK;
      end
      ST_SCAN_CHK: begin
        if (lo_q < hi_q) begin
          state_d = ST_SCAN_CMP;
        end else begin
          res_found_d = 1'b0;
          state_d     = ST_FINISH;
        end
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          res_found_d = 1'b1;
          state_d     = ST_FINISH;
        end else begin
          lo_d    = lo_q + CntW'(1);
          state_d = ST_SCAN_CHK;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_found_d = res_found_q;
          m_idx_d   = res_found_q ? IndexW'(lo_q) : '0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      first_q       <= '0;
      cnt_q         <= '0;
      key_time_q    <= '0;
      key_code_q    <= '0;
      res_found_q   <= 1'b0;
      m_valid_q     <= 1'b0;
      m_found_q     <= 1'b0;
      m_idx_q       <= '0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      lo_q          <= lo_d;
      hi_q          <= hi_d;
      first_q       <= first_d;
      cnt_q         <= cnt_d;
      key_time_q    <= key_time_d;
      key_code_q    <= key_code_d;
      res_found_q   <= res_found_d;
      m_valid_q     <= m_valid_d;
      m_found_q     <= m_found_d;
      m_idx_q       <= m_idx_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - IndexW){1'b0}}, m_idx_q};
  assign m_axis_tuser  = m_found_q;

endmodule

FILE: sv/tbms_checker.sv
// Port-level checker of the time band match search, bound to the top level.
`include "time_band_match_search_macros.svh"

module tbms_port_checker
  import tbms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [0:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [0:0]          m_axis_tuser
);

  `TBMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
  `TBMS_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss beat carries nonzero index")
  `TBMS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_QUERY, !s_axis_tready, "ready after query beat")
  `TBMS_ASSERT_NEXT(a_write_free, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == OP_WRITE, s_axis_tready, "not ready after write beat")
  `TBMS_ASSERT_NOW(a_result_busy, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready), "result appeared without a query at work")

endmodule

bind time_band_match_search tbms_port_checker u_tbms_checker (.*);

FILE: tb/tbms_checker.sv
// Result checker for the time band match search: predicts each query answer and compares it.
module tbms_checker
  import tbms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [CountW-1:0]   cfg_wr_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic [0:0]          m_axis_tuser,
  output int                  fail_count,
  output int                  pending_count
);

  localparam int Depth   = TableDepthDefault;
  localparam int TimeLsb = IndexW;
  localparam int CodeLsb = IndexW + TimeW;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
  } answer_t;

  logic signed [TimeW-1:0] time_mem [Depth];
  logic signed [CodeW-1:0] code_mem [Depth];
  logic [CountW-1:0]       count_q;
  answer_t                 pending_answers [$];

  function automatic answer_t search_table(input logic signed [TimeW-1:0] key_t,
                                           input logic signed [CodeW-1:0] key_c);
    int n, lo, hi, mid, first, last, k;
    answer_t ans;
    n = (count_q > CountW'(Depth)) ? Depth : int'(count_q);
    lo = 0;
    hi = n;
    while (hi > lo && hi - lo > BracketLimit) begin
      mid = (lo + hi) / 2;
      if (time_mem[mid] < key_t) lo = mid;
      else hi = mid + 1;
    end
    first = lo;
    lo = 0;
    hi = n;
    while (hi > lo && hi - lo > BracketLimit) begin
      mid = (lo + hi) / 2;
      if (key_t < time_mem[mid]) hi = mid;
      else lo = mid - 1;
    end
    last = hi;
    ans = '0;
    for (k = first; k < last && k < Depth; k++) begin
      if (!ans.found && time_mem[k] == key_t && code_mem[k] == key_c) begin
        ans.found       = 1'b1;
        ans.match_index = IndexW'(k);
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want, got;
    logic [IndexW-1:0] slot;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        time_mem[i] = '0;
        code_mem[i] = '0;
      end
      count_q = '0;
      pending_answers.delete();
      pending_count = 0;
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found       = m_axis_tuser[0];
        got.match_index = m_axis_tdata[IndexW-1:0];
        if (pending_answers.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: found=%0d index=%0d",
                   $time, got.found, got.match_index);
        end else begin
          want = pending_answers.pop_front();
          pending_count--;
          if (got.found !== want.found || got.match_index !== want.match_index) begin
            fail_count++;
            $display("%0t: mismatch: expected found=%0d index=%0d, actual found=%0d index=%0d",
                     $time, want.found, want.match_index, got.found, got.match_index);
          end
        end
      end
      if (cfg_wr_en_i) count_q = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_QUERY) begin
          pending_answers.push_back(search_table(s_axis_tdata[TimeLsb +: TimeW],
                                                 s_axis_tdata[CodeLsb +: CodeW]));
          pending_count++;
        end else begin
          slot = s_axis_tdata[IndexW-1:0];
          time_mem[slot] = s_axis_tdata[TimeLsb +: TimeW];
          code_mem[slot] = s_axis_tdata[CodeLsb +: CodeW];
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the time band match search: stimulus, back-pressure and verdict.
module tb;
  import tbms_pkg::*;

  localparam int PadW         = InDataW - IndexW - TimeW - CodeW;
  localparam int Depth        = TableDepthDefault;
  localparam int RandomItems  = 1100;
  localparam int FinalItems   = Depth + 20;
  localparam int SettleCycles = 100;
  localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};
  localparam logic signed [TimeW-1:0] TimeMax = {1'b0, {(TimeW-1){1'b1}}};
  localparam logic signed [CodeW-1:0] CodeMin = {1'b1, {(CodeW-1){1'b0}}};
  localparam logic signed [CodeW-1:0] CodeMax = {1'b0, {(CodeW-1){1'b1}}};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_wr_en_i   = 1'b0;
  logic [CountW-1:0]   cfg_wr_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [0:0]          m_axis_tuser;

  int fail_count;
  int pending_count;
  int items_sent;
  int hold_cycles;
  bit quiet;

  logic signed [TimeW-1:0] tbl_time [Depth];
  logic signed [CodeW-1:0] tbl_code [Depth];

  always #1 clk_i = ~clk_i;

  time_band_match_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  tbms_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_wr_en_i  (cfg_wr_en_i),
    .cfg_wr_data_i(cfg_wr_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // Result side back-pressure.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles--;
    else if (!quiet && $urandom_range(0, 9) < 2) hold_cycles = draw_gap();
    m_axis_tready <= (hold_cycles == 0);
  end

  task automatic push_beat(input tbms_op_e op, input logic [IndexW-1:0] idx,
                           input logic signed [TimeW-1:0] t,
                           input logic signed [CodeW-1:0] c);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{PadW{1'b0}}, c, t, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_entry(input int idx, input logic signed [TimeW-1:0] t,
                             input logic signed [CodeW-1:0] c);
    tbl_time[idx] = t;
    tbl_code[idx] = c;
    push_beat(OP_WRITE, IndexW'(idx), t, c);
  endtask

  task automatic query(input logic signed [TimeW-1:0] t, input logic signed [CodeW-1:0] c);
    push_beat(OP_QUERY, IndexW'($urandom), t, c);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input int n);
    wait_idle();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= CountW'(n);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Fill slots 0..n-1, non-decreasing in time unless scrambled.
  task automatic fill_table(input int n, input bit sorted);
    longint t;
    int r, i;
    logic signed [CodeW-1:0] c;
    case ($urandom_range(0, 2))
      0:       t = longint'(TimeMin) + $urandom_range(0, 20);
      1:       t = longint'(int'($urandom));
      default: t = longint'(TimeMax) - $urandom_range(0, 4 * n + 10);
    endcase
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) t = t;
      else if (r < 80) t = t + $urandom_range(1, 4);
      else if (r < 95) t = t + $urandom_range(5, 1000);
      else t = t + $urandom_range(0, 1 << 28);
      if (t > longint'(TimeMax)) t = longint'(TimeMax);
      if ($urandom_range(0, 1) == 0) c = CodeW'($urandom_range(0, 3) - 2);
      else c = CodeW'($urandom);
      if (sorted) write_entry(i, TimeW'(t), c);
      else if ($urandom_range(0, 1) == 0) write_entry(i, TimeW'($urandom_range(0, 7)), c);
      else write_entry(i, TimeW'($urandom), c);
    end
  endtask

  task automatic random_query(input int n);
    int k, r;
    logic signed [TimeW-1:0] kt;
    logic signed [CodeW-1:0] kc;
    k = (n > 0) ? $urandom_range(0, n - 1) : 0;
    kt = tbl_time[k];
    kc = tbl_code[k];
    r = $urandom_range(0, 9);
    if (r == 6) kc = CodeW'($urandom_range(0, 3) - 2);
    else if (r == 7) kt = kt + 1;
    else if (r == 8) kt = TimeW'($urandom);
    else if (r == 9) begin
      kt = TimeW'($urandom);
      kc = CodeW'($urandom);
    end
    query(kt, kc);
  endtask

  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n, q, i;
    for (i = 0; i < Depth; i++) begin
      tbl_time[i] = '0;
      tbl_code[i] = '0;
    end
    quiet = 1'b0;
    hold_cycles = 0;
    items_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table after reset, then a small table with duplicate and extreme times.
    query('0, '0);
    write_entry(0, TimeMin, CodeMin);
    write_entry(1, TimeMin, CodeMax);
    write_entry(2, -5, 1);
    write_entry(3, -1, 2);
    write_entry(4, 0, 7);
    write_entry(5, 0, 3);
    write_entry(6, 0, 7);
    write_entry(7, 7, 0);
    write_entry(8, 100, -1);
    write_entry(9, TimeMax - 1, 5);
    write_entry(10, TimeMax, CodeMin);
    write_entry(11, TimeMax, 0);
    write_entry(Depth - 1, -1, -1);
    set_entry_count(12);
    query(0, 7);
    query(TimeMin, CodeMax);
    query(TimeMax, 0);
    query(TimeMax, CodeMin);
    query(0, 9);
    query(8, 0);
    set_entry_count(1);
    query(TimeMin, CodeMin);

    while (items_sent < RandomItems - FinalItems) begin
      quiet = ($urandom_range(0, 4) == 0);
      q = $urandom_range(0, 99);
      if (q < 15) n = $urandom_range(0, 10);
      else if (q < 75) n = $urandom_range(11, 40);
      else if (q < 95) n = $urandom_range(41, 120);
      else n = $urandom_range(121, 300);
      fill_table(n, $urandom_range(0, 4) != 0);
      set_entry_count(n);
      q = $urandom_range(4, 24);
      repeat (q) begin
        if ($urandom_range(0, 99) < 15)
          write_entry($urandom_range(0, Depth - 1), TimeW'($urandom), CodeW'($urandom));
        else
          random_query(n);
      end
    end

    // Full table, then a count beyond the table depth.
    quiet = 1'b0;
    fill_table(Depth, 1'b1);
    set_entry_count(Depth);
    repeat (12) random_query(Depth);
    set_entry_count((1 << CountW) - 1);
    repeat (8) random_query(Depth);

    wait_idle();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
